// File: hw/rtl/ajb_pkg.sv
// Package for the audio jitter buffer: ring geometry, request codes,
// state encodings, the result layout and the sample saturation helper.
// No dependencies; imported by ajb_ring_ram and audio_jitter_buffer_playout.
`default_nettype none

package ajb_pkg;

  // Ring geometry. The ring holds at most STORE_BYTES-1 bytes.
  localparam int unsigned PTR_W       = 16;
  localparam int unsigned STORE_BYTES = 1 << PTR_W;
  localparam int unsigned LEVEL_W     = 16;
  localparam int unsigned THR_W       = 16;

  // Prefill threshold after reset.
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(32768);

  // Occupancy at which the ring counts as full.
  localparam logic [PTR_W-1:0] HELD_FULL = PTR_W'(STORE_BYTES - 1);

  // Bytes that make up one sample.
  localparam logic [PTR_W-1:0] SAMPLE_BYTES = PTR_W'(2);

  // Request codes carried on the input tuser.
  typedef enum logic [2:0] {
    REQ_PUSH  = 3'd0,
    REQ_PULL  = 3'd1,
    REQ_START = 3'd2,
    REQ_END   = 3'd3,
    REQ_STOP  = 3'd4
  } req_e;

  // Session phase.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_OPEN  = 3'b010,
    PH_ENDED = 3'b100
  } phase_e;

  // Request sequencer: a sample pull adds ST_HI and ST_DONE for memory reads.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_HI   = 3'b010,
    ST_DONE = 3'b100
  } fsm_e;

  // One result item, last field in the lowest bits, padded to whole bytes.
  typedef struct packed {
    logic [1:0]         pad;
    logic               play_active;
    logic               finished;
    logic               underrun;
    logic               overflow_seen;
    logic [LEVEL_W-1:0] buffer_level;
    logic signed [15:0] sample_right;
    logic signed [15:0] sample_left;
    logic               sample_valid;
    logic               accepted;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

  // Double a 16-bit sample with saturation to the signed 16-bit range.
  function automatic logic signed [15:0] sat_double(input logic [15:0] s);
    logic signed [15:0] r;
    if (s[15] != s[14]) begin
      r = s[15] ? 16'sh8000 : 16'sh7fff;
    end else begin
      r = {s[14:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ajb_ring_ram.sv
// Byte store of the jitter buffer ring: one write port, one read port,
// registered read data. Depends on ajb_pkg.
`default_nettype none

module ajb_ring_ram
  import ajb_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [PTR_W-1:0] waddr_i,
  input  wire logic [7:0]       wdata_i,
  input  wire logic [PTR_W-1:0] raddr_i,
  output logic      [7:0]       rdata_o
);

  logic [7:0] mem_q [STORE_BYTES];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/audio_jitter_buffer_playout.sv
// Top level of the audio jitter buffer: request sequencer, ring pointers,
// session flags and the result register. Depends on ajb_pkg and ajb_ring_ram.
//
//  Channel   Direction  Ports                     Content
//  request   in         s_axis_t*                 tuser: req_type, tdata: data_byte
//  result    out        m_axis_t*                 tdata: result_t fields
//  config    in         cfg_we_i, cfg_wdata_i     prefill_threshold
//
// A push, start, end, stop or a pull that yields no sample is answered in
// ST_IDLE. For a pull that yields a sample, ST_HI and ST_DONE follow: the two
// bytes come through the byte store's single read port, with registered data.
// A new request is taken while the previous result is being transferred.
// Reset empties the ring by clearing both pointers; the store needs no clearing.
// While a result waits without being transferred, no new request is taken.
`default_nettype none

module audio_jitter_buffer_playout
  import ajb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Request stream.
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // [7:0] data_byte
  input  wire logic [2:0]          s_axis_tuser,   // [2:0] req_type
  // Result stream.
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [0] accepted, [1] sample_valid, [17:2] sample_left, [33:18] sample_right,
  // [49:34] buffer_level, [50] overflow_seen, [51] underrun, [52] finished,
  // [53] play_active, [55:54] zero
  output logic [RESULT_W-1:0]      m_axis_tdata,
  // Configuration.
  input  wire logic                cfg_we_i,
  input  wire logic [THR_W-1:0]    cfg_wdata_i
);

  fsm_e             fsm_q, fsm_d;
  phase_e           phase_q, phase_d;
  logic [PTR_W-1:0] wp_q, wp_d;
  logic [PTR_W-1:0] rp_q, rp_d;
  logic             overflow_q, overflow_d;
  logic             streaming_q, streaming_d;
  logic             playing_q, playing_d;
  logic [THR_W-1:0] thr_q;
  logic [7:0]       lo_q, lo_d;
  logic             m_valid_q, m_valid_d;
  result_t          res_q, res_d;

  logic             in_xfer;
  logic             load;
  logic             mem_we;
  logic [7:0]       rdata;
  logic [PTR_W-1:0] held;
  logic [PTR_W-1:0] held_d;
  logic             acc, smp_valid, underrun;
  logic signed [15:0] sample;
  req_e             req;

  assign req           = req_e'(s_axis_tuser);
  assign s_axis_tready = (fsm_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign held          = wp_q - rp_q;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = res_q;

  // Byte store. Reads always address the read pointer; writes only happen in
  // the cycle a push is taken, while no pull is reading, so no forwarding.
  ajb_ring_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q),
    .wdata_i (s_axis_tdata),
    .raddr_i (rp_q),
    .rdata_o (rdata)
  );

  // Request decode and sequencing.
  always_comb begin
    fsm_d       = fsm_q;
    phase_d     = phase_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    overflow_d  = overflow_q;
    streaming_d = streaming_q;
    playing_d   = playing_q;
    lo_d        = lo_q;
    load        = 1'b0;
    mem_we      = 1'b0;
    acc         = 1'b0;
    smp_valid   = 1'b0;
    underrun    = 1'b0;
    sample      = '0;

    case (fsm_q)
      ST_IDLE: begin
        if (in_xfer) begin
          load = 1'b1;
          case (req)
            REQ_PUSH: begin
              if (held == HELD_FULL) begin
                overflow_d = 1'b1;
              end else begin
                mem_we = 1'b1;
                wp_d   = wp_q + PTR_W'(1);
                acc    = 1'b1;
              end
            end
            REQ_PULL: begin
              if (phase_q == PH_OPEN &&
                  (playing_q || !streaming_q || held >= thr_q)) begin
                playing_d = 1'b1;
                if (held >= SAMPLE_BYTES) begin
                  // Low byte read is under way; result comes in ST_DONE.
                  load  = 1'b0;
                  rp_d  = rp_q + PTR_W'(1);
                  fsm_d = ST_HI;
                end else if (streaming_q) begin
                  underrun = 1'b1;
                end else begin
                  // Stream over and a lone byte at most: drop it and finish.
                  rp_d      = wp_q;
                  playing_d = 1'b0;
                  phase_d   = PH_ENDED;
                end
              end
            end
            REQ_START: begin
              wp_d        = '0;
              rp_d        = '0;
              overflow_d  = 1'b0;
              streaming_d = 1'b1;
              playing_d   = 1'b0;
              phase_d     = PH_OPEN;
            end
            REQ_END: begin
              streaming_d = 1'b0;
            end
            REQ_STOP: begin
              streaming_d = 1'b0;
              playing_d   = 1'b0;
              phase_d     = PH_ENDED;
            end
            default: begin
            end
          endcase
        end
      end
      ST_HI: begin
        lo_d  = rdata;
        rp_d  = rp_q + PTR_W'(1);
        fsm_d = ST_DONE;
      end
      ST_DONE: begin
        load      = 1'b1;
        smp_valid = 1'b1;
        sample    = sat_double({rdata, lo_q});
        fsm_d     = ST_IDLE;
      end
      default: begin
        fsm_d = ST_IDLE;
      end
    endcase
  end

  // Result assembly from the state after the step.
  assign held_d = wp_d - rp_d;

  always_comb begin
    res_d               = res_q;
    if (load) begin
      res_d.pad           = '0;
      res_d.play_active   = playing_d;
      res_d.finished      = (phase_d == PH_ENDED);
      res_d.underrun      = underrun;
      res_d.overflow_seen = overflow_d;
      res_d.buffer_level  = LEVEL_W'(held_d);
      res_d.sample_right  = sample;
      res_d.sample_left   = sample;
      res_d.sample_valid  = smp_valid;
      res_d.accepted      = acc;
    end
  end

  // Output valid: set on a new result, cleared when the transfer completes.
  always_comb begin
    if (load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= ST_IDLE;
      phase_q     <= PH_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      overflow_q  <= 1'b0;
      streaming_q <= 1'b0;
      playing_q   <= 1'b0;
      thr_q       <= THR_RESET;
      m_valid_q   <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      phase_q     <= phase_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      overflow_q  <= overflow_d;
      streaming_q <= streaming_d;
      playing_q   <= playing_d;
      m_valid_q   <= m_valid_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    res_q <= res_d;
  end

  // A sample read is only started with a whole sample in the ring.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == ST_IDLE && fsm_d == ST_HI) |-> held >= SAMPLE_BYTES)
    else $error("sample read started with fewer than two bytes held");

  // The result register is free by the time a sample is ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == ST_DONE) |-> !m_valid_q)
    else $error("sample result would overwrite a pending result");

  // Playout can only be active inside an open session.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    playing_q |-> (phase_q == PH_OPEN))
    else $error("playout active outside an open session");

  // Overflow is only raised by a refused push into a full ring.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(overflow_q) |-> (held == HELD_FULL))
    else $error("overflow flag set while the ring had room");

endmodule

`default_nettype wire
